// ===== hw/rtl/crsd_pkg.sv =====
`timescale 1ns / 1ps

package crsd_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_LOCAL_ADDR = 3'd0,
		REG_EXT_ADDR   = 3'd1,
		REG_READ_LEN   = 3'd2,
		REG_WRITE_LEN  = 3'd3,
		REG_STATUS     = 3'd4,
		REG_DMA_FULL   = 3'd5,
		REG_DMA_BUSY   = 3'd6,
		REG_SEMAPHORE  = 3'd7
	} reg_idx_t;

	localparam int STATUS_BITS = 15;
	localparam logic [STATUS_BITS-1:0] STATUS_RESET = 15'h0001;

	// status register bits
	localparam int ST_HALT    = 0;
	localparam int ST_BROKE   = 1;
	localparam int ST_SSTEP   = 5;
	localparam int ST_INTBRK  = 6;
	localparam int ST_SIG0    = 7;
	localparam int NUM_SIGNALS = 8;

	// status write command bits
	localparam int SW_CLR_HALT   = 0;
	localparam int SW_SET_HALT   = 1;
	localparam int SW_CLR_BROKE  = 2;
	localparam int SW_IRQ_CLEAR  = 3;
	localparam int SW_IRQ_SET    = 4;
	localparam int SW_CLR_SSTEP  = 5;
	localparam int SW_SET_SSTEP  = 6;
	localparam int SW_CLR_INTBRK = 7;
	localparam int SW_SET_INTBRK = 8;
	localparam int SW_CLR_SIG0   = 9;

	// length word layout
	localparam int LEN_ROW_BITS   = 12;
	localparam int LEN_COUNT_LSB  = 12;
	localparam int LEN_COUNT_BITS = 8;
	localparam int LEN_SKIP_LSB   = 20;
	localparam int LEN_SKIP_BITS  = 12;
	localparam logic [LEN_ROW_BITS-1:0] ROW_MIN_MASK = 12'h007;

	typedef struct packed {
		logic        valid;
		logic        to_external;
		logic [31:0] len;
	} arm_t;

	typedef struct packed {
		logic valid;
		logic to_external;
		logic bank;
	} move_ctl_t;

endpackage

// ===== hw/rtl/coprocessor_regs_with_strided_dma_core.sv =====
`timescale 1ns / 1ps
// channel | group           | contents
// --------+-----------------+-------------------------------------------------
// in      | s_tvalid/tready | tuser: operation, reg_index; tdata: data, mask
// out     | m_tvalid/tready | tdata: read value, byte move, irq/run pulses, busy
//
// one word is taken per cycle while s_tready is high; its result is in the output register in the next cycle
// register decode and the dma address step sit between the input and the output register
// s_tready stays high while the output register is empty or being drained
// a stalled output holds its word and blocks new input only while it is full
// arst_n clears all registers but the output data word; status comes up with halt set

module coprocessor_regs_with_strided_dma_core
	import crsd_pkg::*;
#(
	parameter int LOCAL_ADDR_BITS = 12,
	parameter int EXT_ADDR_BITS   = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,  // write_data, write_mask
	input  logic [4:0]           s_tuser,  // operation, reg_index
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// read_data, move_valid, move_to_external, move_ext_addr, move_local_addr,
	// move_local_bank, irq_set, irq_clear, run_request, dma_busy
	output logic [((39 + EXT_ADDR_BITS + LOCAL_ADDR_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_BITS  = 39 + EXT_ADDR_BITS + LOCAL_ADDR_BITS;
	localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;
	localparam int LREG_BITS = LOCAL_ADDR_BITS + 1;

	logic [LOCAL_ADDR_BITS:0]   local_addr_q;
	logic [EXT_ADDR_BITS-1:0]   ext_addr_q;
	logic [31:0]                read_len_q;
	logic [31:0]                write_len_q;
	logic [STATUS_BITS-1:0]     status_q;
	logic                       sem_q;
	logic                       m_tvalid_q;
	logic [OUT_WIDTH-1:0]       m_tdata_q;

	logic                       accept;
	op_t                        op;
	reg_idx_t                   idx;
	logic [31:0]                wdata;
	logic [31:0]                wmask;
	logic [31:0]                wcmd;
	logic [31:0]                len_merged;

	logic [LOCAL_ADDR_BITS:0]   local_addr_d;
	logic [EXT_ADDR_BITS-1:0]   ext_addr_d;
	logic [31:0]                read_len_d;
	logic [31:0]                write_len_d;
	logic [STATUS_BITS-1:0]     status_d;
	logic [STATUS_BITS-1:0]     status_wr;
	logic                       sem_d;
	logic [31:0]                read_data;
	logic                       irq_set;
	logic                       irq_clear;
	logic                       run_request;

	arm_t                       arm;
	move_ctl_t                  move;
	logic [EXT_ADDR_BITS-1:0]   move_ext_addr;
	logic [LOCAL_ADDR_BITS-1:0] move_local_addr;
	logic                       busy_next;
	logic [OUT_BITS-1:0]        result;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser[1:0]);
	assign idx      = reg_idx_t'(s_tuser[4:2]);
	assign wdata    = s_tdata[31:0];
	assign wmask    = s_tdata[63:32];
	assign wcmd     = wdata & wmask;

	// set/clear pairs: clear first so a set wins
	always_comb begin
		status_wr = status_q;
		if (wcmd[SW_CLR_HALT])   status_wr[ST_HALT] = 1'b0;
		if (wcmd[SW_SET_HALT])   status_wr[ST_HALT] = 1'b1;
		if (wcmd[SW_CLR_BROKE])  status_wr[ST_BROKE] = 1'b0;
		if (wcmd[SW_CLR_SSTEP])  status_wr[ST_SSTEP] = 1'b0;
		if (wcmd[SW_SET_SSTEP])  status_wr[ST_SSTEP] = 1'b1;
		if (wcmd[SW_CLR_INTBRK]) status_wr[ST_INTBRK] = 1'b0;
		if (wcmd[SW_SET_INTBRK]) status_wr[ST_INTBRK] = 1'b1;
		for (int k = 0; k < NUM_SIGNALS; k++) begin
			if (wcmd[SW_CLR_SIG0 + 2 * k])     status_wr[ST_SIG0 + k] = 1'b0;
			if (wcmd[SW_CLR_SIG0 + 2 * k + 1]) status_wr[ST_SIG0 + k] = 1'b1;
		end
	end

	assign len_merged = (idx == REG_WRITE_LEN) ? ((write_len_q & ~wmask) | wdata & wmask)
	                                           : ((read_len_q & ~wmask) | wdata & wmask);

	always_comb begin
		local_addr_d = local_addr_q;
		ext_addr_d   = ext_addr_q;
		read_len_d   = read_len_q;
		write_len_d  = write_len_q;
		status_d     = status_q;
		sem_d        = sem_q;
		read_data    = '0;
		irq_set      = 1'b0;
		irq_clear    = 1'b0;
		run_request  = 1'b0;
		arm          = '0;
		case (op)
			OP_READ: begin
				case (idx)
					REG_LOCAL_ADDR: read_data = 32'(local_addr_q);
					REG_EXT_ADDR:   read_data = 32'(ext_addr_q);
					REG_READ_LEN:   read_data = read_len_q;
					REG_WRITE_LEN:  read_data = write_len_q;
					REG_STATUS:     read_data = 32'(status_q);
					REG_SEMAPHORE: begin
						read_data = 32'(sem_q);
						sem_d     = 1'b1;
					end
					default:        read_data = '0;
				endcase
			end
			OP_WRITE: begin
				case (idx)
					REG_LOCAL_ADDR: local_addr_d = (local_addr_q & ~wmask[LREG_BITS-1:0])
					                             | (wdata[LREG_BITS-1:0] & wmask[LREG_BITS-1:0]);
					REG_EXT_ADDR:   ext_addr_d = (ext_addr_q & ~wmask[EXT_ADDR_BITS-1:0])
					                           | (wdata[EXT_ADDR_BITS-1:0]
					                              & wmask[EXT_ADDR_BITS-1:0]);
					REG_READ_LEN: begin
						read_len_d      = len_merged;
						arm.valid       = 1'b1;
						arm.to_external = 1'b0;
						arm.len         = len_merged;
					end
					REG_WRITE_LEN: begin
						write_len_d     = len_merged;
						arm.valid       = 1'b1;
						arm.to_external = 1'b1;
						arm.len         = len_merged;
					end
					REG_STATUS: begin
						status_d    = status_wr;
						irq_set     = wcmd[SW_IRQ_SET];
						irq_clear   = wcmd[SW_IRQ_CLEAR];
						run_request = (wcmd[SW_CLR_HALT] || wcmd[SW_CLR_BROKE])
						              && !status_wr[ST_HALT] && !status_wr[ST_BROKE];
					end
					REG_SEMAPHORE:  sem_d = 1'b0;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	crsd_dma_engine #(
		.LOCAL_ADDR_BITS(LOCAL_ADDR_BITS),
		.EXT_ADDR_BITS  (EXT_ADDR_BITS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.arm            (accept ? arm : arm_t'('0)),
		.local_start    (local_addr_q),
		.ext_start      (ext_addr_q),
		.tick           (accept && op == OP_TICK),
		.move           (move),
		.move_ext_addr  (move_ext_addr),
		.move_local_addr(move_local_addr),
		.busy_next      (busy_next)
	);

	assign result = {busy_next, run_request, irq_clear, irq_set, move.bank, move_local_addr,
	                 move_ext_addr, move.to_external, move.valid, read_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			ext_addr_q   <= '0;
			read_len_q   <= '0;
			write_len_q  <= '0;
			status_q     <= STATUS_RESET;
			sem_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (accept) begin
				local_addr_q <= local_addr_d;
				ext_addr_q   <= ext_addr_d;
				read_len_q   <= read_len_d;
				write_len_q  <= write_len_d;
				status_q     <= status_d;
				sem_q        <= sem_d;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_WIDTH'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/crsd_dma_engine.sv =====
`timescale 1ns / 1ps

module crsd_dma_engine
	import crsd_pkg::*;
#(
	parameter int LOCAL_ADDR_BITS = 12,
	parameter int EXT_ADDR_BITS   = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  arm_t                       arm,
	input  logic [LOCAL_ADDR_BITS:0]   local_start,
	input  logic [EXT_ADDR_BITS-1:0]   ext_start,
	input  logic                       tick,
	output move_ctl_t                  move,
	output logic [EXT_ADDR_BITS-1:0]   move_ext_addr,
	output logic [LOCAL_ADDR_BITS-1:0] move_local_addr,
	output logic                       busy_next
);

	localparam int ROW_CNT_BITS = LEN_ROW_BITS + 1;
	localparam int ROWS_BITS    = LEN_COUNT_BITS + 1;

	logic                       busy_q;
	logic                       dir_q;
	logic                       bank_q;
	logic [LOCAL_ADDR_BITS-1:0] cur_local_q;
	logic [EXT_ADDR_BITS-1:0]   cur_ext_q;
	logic [ROW_CNT_BITS-1:0]    bytes_left_q;
	logic [ROW_CNT_BITS-1:0]    row_len_q;
	logic [ROWS_BITS-1:0]       rows_left_q;
	logic [LEN_SKIP_BITS-1:0]   row_skip_q;

	logic                       step;
	logic [ROW_CNT_BITS-1:0]    bytes_dec;
	logic [ROWS_BITS-1:0]       rows_dec;
	logic                       row_end;
	logic [EXT_ADDR_BITS-1:0]   ext_inc;
	logic [EXT_ADDR_BITS-1:0]   ext_skip;
	logic [ROW_CNT_BITS-1:0]    arm_row_len;
	logic [ROWS_BITS-1:0]       arm_rows;

	assign step      = tick && busy_q;
	assign bytes_dec = bytes_left_q - ROW_CNT_BITS'(1);
	assign rows_dec  = rows_left_q - ROWS_BITS'(1);
	assign row_end   = (bytes_dec == '0);
	assign ext_inc   = cur_ext_q + EXT_ADDR_BITS'(1);
	assign ext_skip  = ext_inc + EXT_ADDR_BITS'(row_skip_q);

	assign arm_row_len = {1'b0, arm.len[LEN_ROW_BITS-1:0] | ROW_MIN_MASK} + ROW_CNT_BITS'(1);
	assign arm_rows    = {1'b0, arm.len[LEN_COUNT_LSB +: LEN_COUNT_BITS]} + ROWS_BITS'(1);

	assign move.valid       = step;
	assign move.to_external = step ? dir_q : 1'b0;
	assign move.bank        = step ? bank_q : 1'b0;
	assign move_ext_addr    = step ? cur_ext_q : '0;
	assign move_local_addr  = step ? cur_local_q : '0;

	always_comb begin
		busy_next = busy_q;
		if (arm.valid) begin
			busy_next = 1'b1;
		end else if (step && row_end && rows_dec == '0) begin
			busy_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			dir_q        <= 1'b0;
			bank_q       <= 1'b0;
			cur_local_q  <= '0;
			cur_ext_q    <= '0;
			bytes_left_q <= '0;
			row_len_q    <= '0;
			rows_left_q  <= '0;
			row_skip_q   <= '0;
		end else begin
			busy_q <= busy_next;
			if (arm.valid) begin
				dir_q        <= arm.to_external;
				bank_q       <= local_start[LOCAL_ADDR_BITS];
				cur_local_q  <= local_start[LOCAL_ADDR_BITS-1:0];
				cur_ext_q    <= ext_start;
				bytes_left_q <= arm_row_len;
				row_len_q    <= arm_row_len;
				rows_left_q  <= arm_rows;
				row_skip_q   <= arm.len[LEN_SKIP_LSB +: LEN_SKIP_BITS];
			end else if (step) begin
				cur_local_q <= cur_local_q + LOCAL_ADDR_BITS'(1);
				if (row_end) begin
					cur_ext_q   <= ext_skip;
					rows_left_q <= rows_dec;
					if (rows_dec == '0) begin
						bytes_left_q <= bytes_dec;
					end else begin
						bytes_left_q <= row_len_q;
					end
				end else begin
					cur_ext_q    <= ext_inc;
					bytes_left_q <= bytes_dec;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/crsd_checker.sv =====
`timescale 1ns / 1ps

module crsd_checker #(
	parameter int LOCAL_ADDR_BITS = 12,
	parameter int EXT_ADDR_BITS   = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [((39 + EXT_ADDR_BITS + LOCAL_ADDR_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int MV_BIT   = 32;
	localparam int EXT_LSB  = 34;
	localparam int LOC_LSB  = EXT_LSB + EXT_ADDR_BITS;
	localparam int BANK_BIT = LOC_LSB + LOCAL_ADDR_BITS;
	localparam int IRQS_BIT = BANK_BIT + 1;
	localparam int IRQC_BIT = BANK_BIT + 2;
	localparam int RUN_BIT  = BANK_BIT + 3;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word gave no result next cycle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_idle_move_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[MV_BIT] |-> m_tdata[BANK_BIT:MV_BIT + 1] == '0)
		else $error("move fields set without a move");

	a_pulse_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[IRQS_BIT] || m_tdata[IRQC_BIT] || m_tdata[RUN_BIT])
		|-> !m_tdata[MV_BIT] && m_tdata[31:0] == 32'd0)
		else $error("status pulse together with a move or read data");

endmodule

bind coprocessor_regs_with_strided_dma_core crsd_checker #(
	.LOCAL_ADDR_BITS(LOCAL_ADDR_BITS),
	.EXT_ADDR_BITS  (EXT_ADDR_BITS)
) u_crsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== verif/crsd_dma_checker.sv =====
`timescale 1ns / 1ps

module crsd_dma_checker
	import crsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,  // write_data, write_mask
	input  logic [4:0]  s_tuser,  // operation, reg_index
	input  logic        m_tvalid,
	input  logic        m_tready,
	// read_data, move_valid, move_to_external, move_ext_addr, move_local_addr,
	// move_local_bank, irq_set, irq_clear, run_request, dma_busy
	input  logic [79:0] m_tdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] read_data;
		logic        move_valid;
		logic        move_to_external;
		logic [23:0] move_ext_addr;
		logic [11:0] move_local_addr;
		logic        move_local_bank;
		logic        irq_set;
		logic        irq_clear;
		logic        run_request;
		logic        dma_busy;
	} dma_result_t;

	// register file
	logic [12:0] loc_addr;
	logic [23:0] ext_addr;
	logic [31:0] rd_len;
	logic [31:0] wr_len;
	logic [14:0] status;
	logic        sem;

	// transfer engine
	logic        xfer_busy;
	logic        xfer_to_ext;
	logic        xfer_bank;
	logic [11:0] xfer_local;
	logic [23:0] xfer_ext;
	logic [12:0] row_bytes_left;
	logic [12:0] row_len;
	logic [8:0]  rows_left;
	logic [11:0] skip;

	dma_result_t expected_q[$];
	dma_result_t want;
	dma_result_t got;
	int          mismatch_count = 0;

	assign errors = mismatch_count;

	function automatic void clear_model();
		loc_addr = '0;
		ext_addr = '0;
		rd_len = '0;
		wr_len = '0;
		status = STATUS_RESET;
		sem = 1'b0;
		xfer_busy = 1'b0;
		xfer_to_ext = 1'b0;
		xfer_bank = 1'b0;
		xfer_local = '0;
		xfer_ext = '0;
		row_bytes_left = '0;
		row_len = '0;
		rows_left = '0;
		skip = '0;
	endfunction

	function automatic void start_transfer(input logic [31:0] len, input logic to_ext);
		row_len = {1'b0, len[11:0] | ROW_MIN_MASK} + 13'd1;
		rows_left = {1'b0, len[19:12]} + 9'd1;
		skip = len[31:20];
		row_bytes_left = row_len;
		xfer_local = loc_addr[11:0];
		xfer_bank = loc_addr[12];
		xfer_ext = ext_addr;
		xfer_to_ext = to_ext;
		xfer_busy = 1'b1;
	endfunction

	function automatic dma_result_t predict_item(input logic [1:0] op, input reg_idx_t idx,
		input logic [31:0] data, input logic [31:0] mask);
		dma_result_t r;
		logic [31:0] w;
		logic [14:0] st;
		r = '0;
		w = data & mask;
		if (op == OP_READ) begin
			case (idx)
				REG_LOCAL_ADDR: r.read_data = {19'd0, loc_addr};
				REG_EXT_ADDR:   r.read_data = {8'd0, ext_addr};
				REG_READ_LEN:   r.read_data = rd_len;
				REG_WRITE_LEN:  r.read_data = wr_len;
				REG_STATUS:     r.read_data = {17'd0, status};
				REG_SEMAPHORE: begin
					r.read_data = {31'd0, sem};
					sem = 1'b1;
				end
				default:        r.read_data = '0;
			endcase
		end else if (op == OP_WRITE) begin
			case (idx)
				REG_LOCAL_ADDR: loc_addr = (loc_addr & ~mask[12:0]) | (data[12:0] & mask[12:0]);
				REG_EXT_ADDR:   ext_addr = (ext_addr & ~mask[23:0]) | (data[23:0] & mask[23:0]);
				REG_READ_LEN: begin
					rd_len = (rd_len & ~mask) | w;
					start_transfer(rd_len, 1'b0);
				end
				REG_WRITE_LEN: begin
					wr_len = (wr_len & ~mask) | w;
					start_transfer(wr_len, 1'b1);
				end
				REG_STATUS: begin
					// clear goes first so a set in the same word wins
					st = status;
					if (w[SW_CLR_HALT])   st[ST_HALT] = 1'b0;
					if (w[SW_SET_HALT])   st[ST_HALT] = 1'b1;
					if (w[SW_CLR_BROKE])  st[ST_BROKE] = 1'b0;
					if (w[SW_CLR_SSTEP])  st[ST_SSTEP] = 1'b0;
					if (w[SW_SET_SSTEP])  st[ST_SSTEP] = 1'b1;
					if (w[SW_CLR_INTBRK]) st[ST_INTBRK] = 1'b0;
					if (w[SW_SET_INTBRK]) st[ST_INTBRK] = 1'b1;
					for (int k = 0; k < NUM_SIGNALS; k++) begin
						if (w[SW_CLR_SIG0 + 2 * k])     st[ST_SIG0 + k] = 1'b0;
						if (w[SW_CLR_SIG0 + 2 * k + 1]) st[ST_SIG0 + k] = 1'b1;
					end
					status = st;
					r.irq_set = w[SW_IRQ_SET];
					r.irq_clear = w[SW_IRQ_CLEAR];
					r.run_request = (w[SW_CLR_HALT] || w[SW_CLR_BROKE]) &&
						!st[ST_HALT] && !st[ST_BROKE];
				end
				REG_SEMAPHORE:  sem = 1'b0;
				default: ;
			endcase
		end else if (op == OP_TICK && xfer_busy) begin
			r.move_valid = 1'b1;
			r.move_to_external = xfer_to_ext;
			r.move_ext_addr = xfer_ext;
			r.move_local_addr = xfer_local;
			r.move_local_bank = xfer_bank;
			xfer_local = xfer_local + 12'd1;
			xfer_ext = xfer_ext + 24'd1;
			row_bytes_left = row_bytes_left - 13'd1;
			if (row_bytes_left == '0) begin
				xfer_ext = xfer_ext + {12'd0, skip};
				rows_left = rows_left - 9'd1;
				if (rows_left == '0)
					xfer_busy = 1'b0;
				else
					row_bytes_left = row_len;
			end
		end
		r.dma_busy = xfer_busy;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata[31:0];
				got.move_valid = m_tdata[32];
				got.move_to_external = m_tdata[33];
				got.move_ext_addr = m_tdata[57:34];
				got.move_local_addr = m_tdata[69:58];
				got.move_local_bank = m_tdata[70];
				got.irq_set = m_tdata[71];
				got.irq_clear = m_tdata[72];
				got.run_request = m_tdata[73];
				got.dma_busy = m_tdata[74];
				if (expected_q.size() == 0) begin
					$error("output word with nothing expected: %h", m_tdata);
					mismatch_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("read_data", want.read_data, got.read_data);
					check_field("move_valid", want.move_valid, got.move_valid);
					check_field("move_to_external", want.move_to_external, got.move_to_external);
					check_field("move_ext_addr", want.move_ext_addr, got.move_ext_addr);
					check_field("move_local_addr", want.move_local_addr, got.move_local_addr);
					check_field("move_local_bank", want.move_local_bank, got.move_local_bank);
					check_field("irq_set", want.irq_set, got.irq_set);
					check_field("irq_clear", want.irq_clear, got.irq_clear);
					check_field("run_request", want.run_request, got.run_request);
					check_field("dma_busy", want.dma_busy, got.dma_busy);
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_item(s_tuser[1:0], reg_idx_t'(s_tuser[4:2]),
					s_tdata[31:0], s_tdata[63:32]));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== verif/coprocessor_regs_with_strided_dma_core_tb.sv =====
`timescale 1ns / 1ps

module coprocessor_regs_with_strided_dma_core_tb;
	import crsd_pkg::*;

	localparam int        CYCLE_LIMIT = 400000;
	localparam int        ITEM_TARGET = 1300;
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // write_data, write_mask
	logic [4:0]  s_tuser = '0;  // operation, reg_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// read_data, move_valid, move_to_external, move_ext_addr, move_local_addr,
	// move_local_bank, irq_set, irq_clear, run_request, dma_busy
	logic [79:0] m_tdata;

	int          errors;
	int          pending;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          burst_left = 0;
	logic [5:0]  rx_phase = '0;
	logic [1:0]  rx_mode = '0;

	coprocessor_regs_with_strided_dma_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	crsd_dma_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("coprocessor_regs_with_strided_dma_core_tb failed");
			$finish;
		end
	end

	// output stalls: a new mode is drawn each time rx_phase wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_phase <= '0;
			rx_mode <= '0;
		end else begin
			rx_phase <= rx_phase + 6'd1;
			if (rx_phase == '0)
				rx_mode <= 2'($urandom_range(0, 3));
			case (rx_mode)
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= rx_phase[3];
			endcase
		end
	end

	task automatic send_word(input logic [1:0] op, input reg_idx_t idx,
		input logic [31:0] data, input logic [31:0] mask);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {mask, data};
		s_tuser <= {idx, op};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_noise();
		logic [1:0] op;
		op = 2'($urandom_range(0, 2));
		send_word(op, reg_idx_t'($urandom_range(0, 7)), $urandom, $urandom);
	endtask

	// optionally program addresses, then a length, then send ticks for the transfer, at most 163 of them
	task automatic run_transfer();
		logic [31:0] len;
		reg_idx_t    len_reg;
		int          total_bytes;
		int          ticks;
		if ($urandom_range(0, 3) != 0)
			send_word(OP_WRITE, REG_LOCAL_ADDR,
				$urandom | (($urandom_range(0, 2) == 0) ? 32'h0000_0ff8 : 32'h0),
				($urandom_range(0, 3) == 0) ? $urandom : ALL_ONES);
		if ($urandom_range(0, 3) != 0)
			send_word(OP_WRITE, REG_EXT_ADDR,
				$urandom | (($urandom_range(0, 2) == 0) ? 32'h00ff_fff8 : 32'h0),
				($urandom_range(0, 3) == 0) ? $urandom : ALL_ONES);
		len = $urandom;
		case ($urandom_range(0, 9))
			0:       len[11:0] = 12'($urandom_range(0, 200));
			1, 2:    len[11:0] = 12'($urandom_range(0, 40));
			default: len[11:0] = 12'($urandom_range(0, 15));
		endcase
		len[19:12] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		len_reg = $urandom_range(0, 1) ? REG_WRITE_LEN : REG_READ_LEN;
		send_word(OP_WRITE, len_reg, len, ALL_ONES);
		total_bytes = ((len[11:0] | 12'h007) + 1) * (len[19:12] + 1);
		ticks = ((total_bytes > 160) ? 160 : total_bytes) + $urandom_range(0, 3);
		for (int i = 0; i < ticks; i++) begin
			case ($urandom_range(0, 15))
				0: send_word(OP_READ, reg_idx_t'($urandom_range(0, 7)), $urandom, $urandom);
				1: send_word(OP_WRITE, REG_STATUS, $urandom, $urandom);
				2: send_word(OP_WRITE, REG_SEMAPHORE, $urandom, $urandom);
				default: ;
			endcase
			send_word(OP_TICK, reg_idx_t'($urandom_range(0, 7)), $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values and semaphore behavior
		send_word(OP_READ, REG_STATUS, '0, '0);
		send_word(OP_READ, REG_SEMAPHORE, '0, '0);
		send_word(OP_READ, REG_SEMAPHORE, ALL_ONES, ALL_ONES);
		send_word(OP_WRITE, REG_SEMAPHORE, '0, '0);
		send_word(OP_READ, REG_SEMAPHORE, '0, '0);
		// address registers at their extremes
		send_word(OP_WRITE, REG_LOCAL_ADDR, ALL_ONES, ALL_ONES);
		send_word(OP_READ, REG_LOCAL_ADDR, '0, '0);
		send_word(OP_WRITE, REG_EXT_ADDR, ALL_ONES, ALL_ONES);
		send_word(OP_READ, REG_EXT_ADDR, '0, '0);
		// status: every set and clear at once, then clear halt and broke
		send_word(OP_WRITE, REG_STATUS, ALL_ONES, ALL_ONES);
		send_word(OP_READ, REG_STATUS, '0, '0);
		send_word(OP_WRITE, REG_STATUS, 32'h0000_0005, 32'h0000_0005);
		send_word(OP_READ, REG_STATUS, '0, '0);
		send_word(OP_WRITE, REG_STATUS, ALL_ONES, '0);
		// idle tick and the unused operation code
		send_word(OP_TICK, REG_LOCAL_ADDR, '0, '0);
		send_word(OP_UNUSED, REG_STATUS, ALL_ONES, ALL_ONES);
		// shortest transfer, wrapping both addresses
		send_word(OP_WRITE, REG_READ_LEN, '0, ALL_ONES);
		repeat (3) send_word(OP_TICK, REG_LOCAL_ADDR, '0, '0);
		// longest length word replaces the running transfer
		send_word(OP_WRITE, REG_WRITE_LEN, ALL_ONES, ALL_ONES);
		repeat (2) send_word(OP_TICK, REG_LOCAL_ADDR, '0, '0);
		send_word(OP_READ, REG_WRITE_LEN, '0, '0);
		// flag words that ignore writes
		send_word(OP_WRITE, REG_DMA_FULL, ALL_ONES, ALL_ONES);
		send_word(OP_WRITE, REG_DMA_BUSY, ALL_ONES, ALL_ONES);
		send_word(OP_READ, REG_DMA_FULL, '0, '0);
		send_word(OP_READ, REG_DMA_BUSY, '0, '0);

		while (words_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) != 0)
				run_transfer();
			else
				repeat ($urandom_range(1, 6)) send_noise();
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("coprocessor_regs_with_strided_dma_core_tb passed");
		else
			$display("coprocessor_regs_with_strided_dma_core_tb failed");
		$finish;
	end

endmodule
